@@ design/sacl_pkg.sv @@
package sacl_pkg;

  // Field and register widths
  localparam int ADDR_W  = 64;
  localparam int TAG_W   = 64;
  localparam int AGE_W   = 32;
  localparam int CNT_W   = 32;
  localparam int STAMP_W = 64;
  localparam int OP_W    = 2;
  localparam int OC_W    = 2;
  localparam int SB_W    = 3;
  localparam int WR_W    = 4;
  localparam int BB_W    = 6;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 6;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_SET_BITS   = 2'd0;
  localparam logic [CFG_AW-1:0] REG_WAYS       = 2'd1;
  localparam logic [CFG_AW-1:0] REG_BLOCK_BITS = 2'd2;

  // Record kinds
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
  localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;

  typedef enum logic [OC_W-1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_STAMP,
    ST_DELTA,
    ST_SCAN,
    ST_FINISH,
    ST_EMIT
  } state_t;

  // One cache line as stored
  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } line_t;

  // Sequencer to way unit
  typedef struct packed {
    logic clr;
    logic en;
    logic lookup;
  } scan_ctrl_t;

  // Way unit to sequencer
  typedef struct packed {
    logic hit;
    logic inv;
  } scan_stat_t;

endpackage

@@ design/sacl_ram.sv @@
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/sacl_scan_unit.sv @@
module sacl_scan_unit #(
  parameter int WAY_W = 3
) (
  input  logic                      clk,
  input  sacl_pkg::scan_ctrl_t      ctrl,
  input  logic [WAY_W-1:0]          way,
  input  logic [sacl_pkg::TAG_W-1:0] tag,
  input  logic [sacl_pkg::AGE_W-1:0] delta,
  input  sacl_pkg::line_t           rd_line,
  output sacl_pkg::line_t           wr_line,
  output sacl_pkg::scan_stat_t      stat,
  output logic [WAY_W-1:0]          inv_way,
  output logic [WAY_W-1:0]          victim_way
);
  import sacl_pkg::*;

  logic [AGE_W:0]   sum;
  logic [AGE_W-1:0] caught_age;
  logic             match;

  logic             hit_r, hit_nxt;
  logic             inv_r, inv_nxt;
  logic [WAY_W-1:0] inv_way_r, inv_way_nxt;
  logic [WAY_W-1:0] victim_r, victim_nxt;
  logic [AGE_W-1:0] oldest_r, oldest_nxt;

  // Bring the line's age up to date, saturating; invalid lines do not age
  always_comb begin
    sum = {1'b0, rd_line.age} + {1'b0, delta};
    if (!rd_line.valid) begin
      caught_age = rd_line.age;
    end else if (sum[AGE_W]) begin
      caught_age = '1;
    end else begin
      caught_age = sum[AGE_W-1:0];
    end
    match = ctrl.lookup && rd_line.valid && (rd_line.tag == tag) && !hit_r;
  end

  // Write-back line: first matching way gets its age cleared
  always_comb begin
    wr_line       = rd_line;
    wr_line.age   = match ? '0 : caught_age;
  end

  // Track first hit, first invalid way and first strictly oldest way
  always_comb begin
    hit_nxt     = hit_r;
    inv_nxt     = inv_r;
    inv_way_nxt = inv_way_r;
    victim_nxt  = victim_r;
    oldest_nxt  = oldest_r;
    if (ctrl.clr) begin
      hit_nxt    = 1'b0;
      inv_nxt    = 1'b0;
      victim_nxt = '0;
      oldest_nxt = '0;
    end else if (ctrl.en) begin
      if (match) begin
        hit_nxt = 1'b1;
      end
      if (!rd_line.valid && !inv_r) begin
        inv_nxt     = 1'b1;
        inv_way_nxt = way;
      end
      if (caught_age > oldest_r) begin
        oldest_nxt = caught_age;
        victim_nxt = way;
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_r     <= hit_nxt;
    inv_r     <= inv_nxt;
    inv_way_r <= inv_way_nxt;
    victim_r  <= victim_nxt;
    oldest_r  <= oldest_nxt;
  end

  assign stat.hit   = hit_r;
  assign stat.inv   = inv_r;
  assign inv_way    = inv_way_r;
  assign victim_way = victim_r;

endmodule

@@ design/set_assoc_lru_cache_sim_unit.sv @@
// Set-associative cache model with LRU replacement and running hit, miss and
// eviction counts. Each request on the input carries one trace record (kind in
// in_tuser, address in in_tdata); loads and stores give one result, a modify
// gives two (tlast on the second), an unknown kind gives none. An access passes
// from acceptance to the result register through a stamp read, an age-delta
// step, each way in use in turn through the shared age/tag unit, a finish step
// that writes the stamp memory and, on a miss, the line memory, and the result
// load; a modify runs the access twice. Line ages are kept lazily against a
// per-set record stamp. After reset the line and stamp memories are cleared
// entry by entry with in_tready low. After any register write a resync pass
// over every set brings all ages up to date before the next record is taken;
// registers may be written while it runs.
module set_assoc_lru_cache_sim_unit #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input records
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [sacl_pkg::ADDR_W-1:0]    in_tdata,   // [63:0] address
  input  logic [sacl_pkg::OP_W-1:0]      in_tuser,   // [1:0] op
  // access results
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [3*sacl_pkg::CNT_W-1:0]   out_tdata,  // [31:0] hits_total,
                                                     // [63:32] misses_total,
                                                     // [95:64] evictions_total
  output logic [sacl_pkg::OC_W-1:0]      out_tuser,  // [1:0] outcome
  output logic                           out_tlast,
  // configuration
  input  logic                           cfg_we,
  input  logic [sacl_pkg::CFG_AW-1:0]    cfg_index,
  input  logic [sacl_pkg::CFG_DW-1:0]    cfg_wdata
);
  import sacl_pkg::*;

  localparam int SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LADDR_W = SET_W + WAY_W;
  localparam int NSET    = 1 << SET_W;
  localparam int LDEPTH  = 1 << LADDR_W;

  // Control state
  state_t           state_r, state_nxt;
  logic             sync_r, sync_nxt;
  logic             second_r, second_nxt;
  logic             pending_r, pending_nxt;
  logic [SET_W-1:0] set_r, set_nxt;
  logic [WAY_W-1:0] way_r, way_nxt;
  logic [STAMP_W-1:0] rec_cnt_r, rec_cnt_nxt;
  logic [CNT_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic [CNT_W-1:0] miss_cnt_r, miss_cnt_nxt;
  logic [CNT_W-1:0] evict_cnt_r, evict_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Written and applied configuration
  logic [SB_W-1:0]  cfg_sb_r, cfg_sb_nxt;
  logic [WR_W-1:0]  cfg_ways_r, cfg_ways_nxt;
  logic [BB_W-1:0]  cfg_bb_r, cfg_bb_nxt;
  logic [SB_W-1:0]  app_sb_r, app_sb_nxt;
  logic [WAY_W-1:0] app_lw_r, app_lw_nxt;
  logic [BB_W-1:0]  app_bb_r, app_bb_nxt;

  // Payload
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [ADDR_W-1:0] shifted_r, shifted_nxt;
  logic [TAG_W-1:0]  tag_r, tag_nxt;
  logic [AGE_W-1:0]  delta_r, delta_nxt;
  outcome_t          outcome_r, outcome_nxt;
  logic              last_r, last_nxt;
  outcome_t          out_outcome_r, out_outcome_nxt;
  logic              out_last_r, out_last_nxt;
  logic [CNT_W-1:0]  out_hits_r, out_hits_nxt;
  logic [CNT_W-1:0]  out_miss_r, out_miss_nxt;
  logic [CNT_W-1:0]  out_evict_r, out_evict_nxt;

  // Memory ports
  logic               lram_we;
  logic [LADDR_W-1:0] lram_waddr, lram_raddr;
  line_t              lram_wdata, lram_rdata;
  logic               sram_we;
  logic [SET_W-1:0]   sram_waddr, sram_raddr;
  logic [STAMP_W-1:0] sram_wdata, sram_rdata;

  // Way unit
  scan_ctrl_t       scan_ctrl;
  scan_stat_t       scan_stat;
  line_t            scan_wr;
  logic [WAY_W-1:0] inv_way, victim_way;

  // Misc combinational
  logic [SET_W-1:0]   set_idx;
  logic [STAMP_W-1:0] diff;
  logic [SB_W-1:0]    eff_sb;
  logic [WAY_W-1:0]   eff_lw;
  logic               is_access;
  logic               out_free;

  sacl_ram #(.WIDTH($bits(line_t)), .DEPTH(LDEPTH)) u_line_ram (
    .clk   (clk),
    .we    (lram_we),
    .waddr (lram_waddr),
    .wdata (lram_wdata),
    .raddr (lram_raddr),
    .rdata (lram_rdata)
  );

  sacl_ram #(.WIDTH(STAMP_W), .DEPTH(NSET)) u_stamp_ram (
    .clk   (clk),
    .we    (sram_we),
    .waddr (sram_waddr),
    .wdata (sram_wdata),
    .raddr (sram_raddr),
    .rdata (sram_rdata)
  );

  sacl_scan_unit #(.WAY_W(WAY_W)) u_scan (
    .clk        (clk),
    .ctrl       (scan_ctrl),
    .way        (way_r),
    .tag        (tag_r),
    .delta      (delta_r),
    .rd_line    (lram_rdata),
    .wr_line    (scan_wr),
    .stat       (scan_stat),
    .inv_way    (inv_way),
    .victim_way (victim_way)
  );

  // Effective register values, clamped to the built sizes
  always_comb begin
    if (int'(cfg_sb_r) > MAX_SET_BITS) begin
      eff_sb = SB_W'(MAX_SET_BITS);
    end else begin
      eff_sb = cfg_sb_r;
    end
    if (cfg_ways_r == '0) begin
      eff_lw = '0;
    end else if (int'(cfg_ways_r) > MAX_WAYS) begin
      eff_lw = WAY_W'(MAX_WAYS - 1);
    end else begin
      eff_lw = WAY_W'(cfg_ways_r - 1'b1);
    end
  end

  // Address split: set index and tag from the offset-stripped address
  assign set_idx   = shifted_r[SET_W-1:0] & ~({SET_W{1'b1}} << app_sb_r);
  assign diff      = rec_cnt_r - sram_rdata;
  assign is_access = (in_tuser == OP_LOAD) || (in_tuser == OP_STORE) ||
                     (in_tuser == OP_MODIFY);
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && !pending_r;

  // Sequencer: next state and datapath controls
  always_comb begin
    state_nxt       = state_r;
    sync_nxt        = sync_r;
    second_nxt      = second_r;
    pending_nxt     = pending_r;
    set_nxt         = set_r;
    way_nxt         = way_r;
    rec_cnt_nxt     = rec_cnt_r;
    hit_cnt_nxt     = hit_cnt_r;
    miss_cnt_nxt    = miss_cnt_r;
    evict_cnt_nxt   = evict_cnt_r;
    out_valid_nxt   = out_valid_r;
    cfg_sb_nxt      = cfg_sb_r;
    cfg_ways_nxt    = cfg_ways_r;
    cfg_bb_nxt      = cfg_bb_r;
    app_sb_nxt      = app_sb_r;
    app_lw_nxt      = app_lw_r;
    app_bb_nxt      = app_bb_r;
    op_nxt          = op_r;
    shifted_nxt     = shifted_r;
    tag_nxt         = tag_r;
    delta_nxt       = delta_r;
    outcome_nxt     = outcome_r;
    last_nxt        = last_r;
    out_outcome_nxt = out_outcome_r;
    out_last_nxt    = out_last_r;
    out_hits_nxt    = out_hits_r;
    out_miss_nxt    = out_miss_r;
    out_evict_nxt   = out_evict_r;

    lram_we    = 1'b0;
    lram_waddr = {set_r, way_r};
    lram_wdata = scan_wr;
    lram_raddr = {set_r, WAY_W'(way_r + 1'b1)};
    sram_we    = 1'b0;
    sram_waddr = set_r;
    sram_wdata = rec_cnt_r;
    sram_raddr = set_r;

    scan_ctrl.clr    = 1'b0;
    scan_ctrl.en     = 1'b0;
    scan_ctrl.lookup = !sync_r;

    // result taken
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // clear both memories after reset
      ST_CLEAR: begin
        lram_we    = 1'b1;
        lram_wdata = '0;
        sram_we    = 1'b1;
        sram_wdata = '0;
        {set_nxt, way_nxt} = LADDR_W'({set_r, way_r} + 1'b1);
        if (&{set_r, way_r}) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (pending_r) begin
          sync_nxt  = 1'b1;
          set_nxt   = '0;
          state_nxt = ST_STAMP;
        end else if (in_tvalid) begin
          if (is_access) begin
            op_nxt      = in_tuser;
            shifted_nxt = in_tdata >> app_bb_r;
            second_nxt  = 1'b0;
            state_nxt   = ST_STAMP;
          end else begin
            // unknown kind: lines only age
            rec_cnt_nxt = rec_cnt_r + 1'b1;
          end
        end
      end

      // read the set's stamp; on an access also latch set and tag
      ST_STAMP: begin
        scan_ctrl.clr = 1'b1;
        if (!sync_r) begin
          sram_raddr = set_idx;
          set_nxt    = set_idx;
          tag_nxt    = shifted_r >> app_sb_r;
        end
        state_nxt = ST_DELTA;
      end

      // records since the set was last brought up to date (zero for unused sets in a resync)
      ST_DELTA: begin
        if (|diff[STAMP_W-1:AGE_W]) begin
          delta_nxt = '1;
        end else begin
          delta_nxt = diff[AGE_W-1:0];
        end
        if (sync_r && ((set_r >> app_sb_r) != '0)) begin
          delta_nxt = '0;
        end
        lram_raddr = {set_r, {WAY_W{1'b0}}};
        way_nxt    = '0;
        state_nxt  = ST_SCAN;
      end

      // one way per cycle through the way unit
      ST_SCAN: begin
        scan_ctrl.en = 1'b1;
        lram_we      = 1'b1;
        if (way_r == app_lw_r) begin
          state_nxt = ST_FINISH;
        end else begin
          way_nxt = WAY_W'(way_r + 1'b1);
        end
      end

      ST_FINISH: begin
        sram_we = 1'b1;
        if (sync_r) begin
          if (set_r == '1) begin
            sync_nxt    = 1'b0;
            pending_nxt = 1'b0;
            set_nxt     = '0;
            app_sb_nxt  = eff_sb;
            app_lw_nxt  = eff_lw;
            app_bb_nxt  = cfg_bb_r;
            state_nxt   = ST_IDLE;
          end else begin
            set_nxt   = SET_W'(set_r + 1'b1);
            state_nxt = ST_STAMP;
          end
        end else begin
          lram_wdata.valid = 1'b1;
          lram_wdata.tag   = tag_r;
          lram_wdata.age   = '0;
          if (scan_stat.hit) begin
            outcome_nxt = OUT_HIT;
            hit_cnt_nxt = hit_cnt_r + 1'b1;
          end else if (scan_stat.inv) begin
            outcome_nxt  = OUT_FILL;
            miss_cnt_nxt = miss_cnt_r + 1'b1;
            lram_we      = 1'b1;
            lram_waddr   = {set_r, inv_way};
          end else begin
            outcome_nxt   = OUT_EVICT;
            miss_cnt_nxt  = miss_cnt_r + 1'b1;
            evict_cnt_nxt = evict_cnt_r + 1'b1;
            lram_we       = 1'b1;
            lram_waddr    = {set_r, victim_way};
          end
          last_nxt  = !((op_r == OP_MODIFY) && !second_r);
          state_nxt = ST_EMIT;
        end
      end

      // load the result register once it is free
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_outcome_nxt = outcome_r;
          out_last_nxt    = last_r;
          out_hits_nxt    = hit_cnt_r;
          out_miss_nxt    = miss_cnt_r;
          out_evict_nxt   = evict_cnt_r;
          if (!last_r) begin
            second_nxt = 1'b1;
            state_nxt  = ST_STAMP;
          end else begin
            rec_cnt_nxt = rec_cnt_r + 1'b1;
            state_nxt   = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // register writes; a write to any of the three registers schedules a resync
    if (cfg_we) begin
      case (cfg_index)
        REG_SET_BITS: begin
          cfg_sb_nxt  = cfg_wdata[SB_W-1:0];
          pending_nxt = 1'b1;
        end
        REG_WAYS: begin
          cfg_ways_nxt = cfg_wdata[WR_W-1:0];
          pending_nxt  = 1'b1;
        end
        REG_BLOCK_BITS: begin
          cfg_bb_nxt  = cfg_wdata[BB_W-1:0];
          pending_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r      <= 1'b0;
      second_r    <= 1'b0;
      pending_r   <= 1'b0;
      set_r       <= '0;
      way_r       <= '0;
      rec_cnt_r   <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
      out_valid_r <= 1'b0;
      cfg_sb_r    <= '0;
      cfg_ways_r  <= WR_W'(1);
      cfg_bb_r    <= '0;
      app_sb_r    <= '0;
      app_lw_r    <= '0;
      app_bb_r    <= '0;
    end else begin
      sync_r      <= sync_nxt;
      second_r    <= second_nxt;
      pending_r   <= pending_nxt;
      set_r       <= set_nxt;
      way_r       <= way_nxt;
      rec_cnt_r   <= rec_cnt_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      evict_cnt_r <= evict_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_sb_r    <= cfg_sb_nxt;
      cfg_ways_r  <= cfg_ways_nxt;
      cfg_bb_r    <= cfg_bb_nxt;
      app_sb_r    <= app_sb_nxt;
      app_lw_r    <= app_lw_nxt;
      app_bb_r    <= app_bb_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    shifted_r     <= shifted_nxt;
    tag_r         <= tag_nxt;
    delta_r       <= delta_nxt;
    outcome_r     <= outcome_nxt;
    last_r        <= last_nxt;
    out_outcome_r <= out_outcome_nxt;
    out_last_r    <= out_last_nxt;
    out_hits_r    <= out_hits_nxt;
    out_miss_r    <= out_miss_nxt;
    out_evict_r   <= out_evict_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_evict_r, out_miss_r, out_hits_r};
  assign out_tuser  = out_outcome_r;
  assign out_tlast  = out_last_r;

endmodule

@@ design/sacl_checker.sv @@
module sacl_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic [sacl_pkg::OP_W-1:0]    in_tuser,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [3*sacl_pkg::CNT_W-1:0] out_tdata,
  input logic [sacl_pkg::OC_W-1:0]    out_tuser,
  input logic                         out_tlast
);
  import sacl_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Only the three outcome codes are ever shown
  a_out_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == OUT_HIT) || (out_tuser == OUT_FILL) ||
                   (out_tuser == OUT_EVICT))
    else $error("bad outcome code");

  // An accepted access record keeps the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready &&
      ((in_tuser == OP_LOAD) || (in_tuser == OP_STORE) || (in_tuser == OP_MODIFY))
      |=> !in_tready)
    else $error("ready right after an access request");

  // The clearing pass follows reset
  a_clear: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("ready during clearing pass");

  // No result appears in the cycle after a request is taken
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result without lookup");

endmodule

bind set_assoc_lru_cache_sim_unit sacl_checker u_sacl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

@@ verif/set_assoc_lru_cache_sim_unit_test.sv @@
module set_assoc_lru_cache_sim_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sacl_pkg::*;

  localparam int SETS_LOG_MAX = 6;
  localparam int WAY_SLOTS    = 8;
  localparam int LINE_SLOTS   = (1 << SETS_LOG_MAX) * WAY_SLOTS;
  localparam int RECORD_GOAL  = 1350;
  localparam int SETTLE       = 64;
  localparam int STALL_LIMIT  = 8000;
  localparam int SHOW_LIMIT   = 10;
  localparam int DIR_ROWS     = 34;

  // record kind with no access
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam bit REC_ROW = 1'b0;
  localparam bit CFG_ROW = 1'b1;

  typedef struct packed {
    outcome_t         oc;
    logic             last;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] evicts;
  } access_result_t;

  // directed row: a record or a register write; typed rows carry their result
  typedef struct packed {
    bit               is_cfg;
    logic [1:0]       sel;
    logic [63:0]      value;
    bit               typed;
    outcome_t         oc;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] evicts;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [ADDR_W-1:0]    in_tdata   = '0;
  logic [OP_W-1:0]      in_tuser   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [3*CNT_W-1:0]   out_tdata;
  logic [OC_W-1:0]      out_tuser;
  logic                 out_tlast;
  logic                 cfg_we     = 1'b0;
  logic [CFG_AW-1:0]    cfg_index  = '0;
  logic [CFG_DW-1:0]    cfg_wdata  = '0;

  set_assoc_lru_cache_sim_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // cache image and counters kept by the predictor
  logic             cache_valid [LINE_SLOTS];
  logic [TAG_W-1:0] cache_tag   [LINE_SLOTS];
  logic [AGE_W-1:0] cache_age   [LINE_SLOTS];
  logic [CNT_W-1:0] hit_cnt, miss_cnt, evict_cnt;
  logic [SB_W-1:0]  cur_set_bits;
  logic [WR_W-1:0]  cur_ways;
  logic [BB_W-1:0]  cur_block_bits;

  access_result_t expected_results [$];

  int  errors       = 0;
  int  records_sent = 0;
  int  results_seen = 0;
  int  seen_hits    = 0;
  int  seen_fills   = 0;
  int  seen_evicts  = 0;
  int  phases       = 0;
  int  burst_left   = 0;
  bit  gaps_on      = 1'b1;

  function automatic int sets_log();
    return (cur_set_bits > SETS_LOG_MAX) ? SETS_LOG_MAX : int'(cur_set_bits);
  endfunction

  function automatic int ways_live();
    if (cur_ways == 0) return 1;
    return (cur_ways > WAY_SLOTS) ? WAY_SLOTS : int'(cur_ways);
  endfunction

  // one access: lookup, then fill or LRU replacement
  function automatic outcome_t cache_access(input logic [ADDR_W-1:0] addr);
    int               sb;
    int               nw;
    int               shift;
    int               base;
    int               victim;
    logic [TAG_W-1:0] tag;
    logic [63:0]      set_idx;
    logic [AGE_W-1:0] oldest;
    sb = sets_log();
    nw = ways_live();
    shift = int'(cur_block_bits) + sb;
    tag = (shift >= 64) ? '0 : (addr >> shift);
    set_idx = (addr >> cur_block_bits) & ((64'd1 << sb) - 64'd1);
    base = int'(set_idx) * WAY_SLOTS;
    for (int w = 0; w < nw; w++) begin
      if (cache_valid[base+w] && cache_tag[base+w] == tag) begin
        hit_cnt++;
        cache_age[base+w] = '0;
        return OUT_HIT;
      end
    end
    miss_cnt++;
    for (int w = 0; w < nw; w++) begin
      if (!cache_valid[base+w]) begin
        cache_valid[base+w] = 1'b1;
        cache_tag[base+w] = tag;
        cache_age[base+w] = '0;
        return OUT_FILL;
      end
    end
    evict_cnt++;
    victim = 0;
    oldest = '0;
    for (int w = 0; w < nw; w++) begin
      if (cache_age[base+w] > oldest) begin
        oldest = cache_age[base+w];
        victim = w;
      end
    end
    cache_tag[base+victim] = tag;
    cache_age[base+victim] = '0;
    return OUT_EVICT;
  endfunction

  // whole record: its accesses, then aging of the lines in use
  task automatic predict_record(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
    outcome_t oc;
    int       nsets;
    int       nw;
    int       k;
    if (op == OP_MODIFY) begin
      oc = cache_access(addr);
      expected_results.push_back('{oc, 1'b0, hit_cnt, miss_cnt, evict_cnt});
      oc = cache_access(addr);
      expected_results.push_back('{oc, 1'b1, hit_cnt, miss_cnt, evict_cnt});
    end else if (op == OP_LOAD || op == OP_STORE) begin
      oc = cache_access(addr);
      expected_results.push_back('{oc, 1'b1, hit_cnt, miss_cnt, evict_cnt});
    end
    nsets = 1 << sets_log();
    nw = ways_live();
    for (int s = 0; s < nsets; s++) begin
      for (int w = 0; w < nw; w++) begin
        k = s * WAY_SLOTS + w;
        if (cache_valid[k] && cache_age[k] != '1) cache_age[k]++;
      end
    end
  endtask

  // send one request, with burst/gap pacing
  task automatic send_record(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    predict_record(op, addr);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= addr;
    do @(posedge clk); while (!in_tready);
    records_sent++;
  endtask

  // stop sending, let every pending result arrive, then let the block settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_SET_BITS:   cur_set_bits   = val[SB_W-1:0];
      REG_WAYS:       cur_ways       = val[WR_W-1:0];
      REG_BLOCK_BITS: cur_block_bits = val[BB_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // directed stimulus
  stim_row_t dir_rows [DIR_ROWS];

  initial begin
    dir_rows = '{
      // fresh cache, one way, one set
      '{REC_ROW, OP_LOAD,   64'h0,                1'b1, OUT_FILL,  32'd0, 32'd1, 32'd0},
      '{REC_ROW, OP_STORE,  64'h0,                1'b1, OUT_HIT,   32'd1, 32'd1, 32'd0},
      '{REC_ROW, OP_LOAD,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, OUT_EVICT, 32'd1, 32'd2, 32'd1},
      '{REC_ROW, OP_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0},
      // unknown kind: no results, lines still age
      '{REC_ROW, OP_NONE,   64'h5A5A_A5A5_5A5A_A5A5, 1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0},
      '{REC_ROW, OP_MODIFY, 64'h1234,             1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0},
      // set bits past the maximum, way count of zero
      '{CFG_ROW, REG_SET_BITS, 64'd7,             1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0},
      '{CFG_ROW, REG_WAYS,     64'd0,             1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0},
      '{REC_ROW, OP_LOAD,   64'h40,               1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0},
      '{REC_ROW, OP_LOAD,   64'h80,               1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0},
      // way count past the maximum
      '{CFG_ROW, REG_WAYS,     64'd15,            1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0},
      '{REC_ROW, OP_LOAD,   64'h0,                1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0},
      '{REC_ROW, OP_STORE,  64'h40,               1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0},
      '{REC_ROW, OP_LOAD,   64'h80,               1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0},
      '{REC_ROW, OP_LOAD,   64'h3F,               1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0},
      // tag shifted out past the address
      '{CFG_ROW, REG_BLOCK_BITS, 64'd63,          1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0},
      '{REC_ROW, OP_LOAD,   64'h0123_4567_89AB_CDEF, 1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0},
      '{REC_ROW, OP_MODIFY, 64'h8000_0000_0000_0000, 1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0},
      '{CFG_ROW, REG_SET_BITS, 64'd0,             1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0},
      '{REC_ROW, OP_LOAD,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0},
      // 8 sets x 4 ways, fill one set and force a replacement
      '{CFG_ROW, REG_SET_BITS, 64'd3,             1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0},
      '{CFG_ROW, REG_BLOCK_BITS, 64'd4,           1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0},
      '{CFG_ROW, REG_WAYS,     64'd4,             1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0},
      '{REC_ROW, OP_LOAD,   64'h1000,             1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0},
      '{REC_ROW, OP_LOAD,   64'h0080,             1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0},
      '{REC_ROW, OP_LOAD,   64'h0100,             1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0},
      '{REC_ROW, OP_LOAD,   64'h0180,             1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0},
      '{REC_ROW, OP_STORE,  64'h0200,             1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0},
      '{REC_ROW, OP_LOAD,   64'h0000,             1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0},
      // shrink the ways, then bring the parked lines back
      '{CFG_ROW, REG_WAYS,     64'd2,             1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0},
      '{REC_ROW, OP_LOAD,   64'h0180,             1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0},
      '{CFG_ROW, REG_WAYS,     64'd4,             1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0},
      '{REC_ROW, OP_LOAD,   64'h0180,             1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0},
      '{REC_ROW, OP_MODIFY, 64'h0008,             1'b0, OUT_HIT,   32'd0, 32'd0, 32'd0}
    };
  end

  // receiver: runs of ready and stall, some of them long
  always @(posedge clk) begin : rx_pace
    int  run_left;
    bit  run_ready;
    if (run_left == 0) begin
      run_ready = $urandom_range(0, 1);
      if (run_ready) run_left = $urandom_range(1, 16);
      else run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 3);
    end
    run_left--;
    out_tready <= run_ready;
  end

  // result check against the oldest pending expectation
  always @(posedge clk) begin : result_check
    access_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      case (outcome_t'(out_tuser))
        OUT_HIT:   seen_hits++;
        OUT_FILL:  seen_fills++;
        OUT_EVICT: seen_evicts++;
        default: ;
      endcase
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= SHOW_LIMIT)
          $display("unexpected result: outcome %0d last %0b data %h",
                   out_tuser, out_tlast, out_tdata);
      end else begin
        e = expected_results.pop_front();
        if (out_tuser !== e.oc || out_tlast !== e.last ||
            out_tdata !== {e.evicts, e.misses, e.hits}) begin
          errors++;
          if (errors <= SHOW_LIMIT)
            $display("mismatch: exp oc %0d last %0b h %0d m %0d e %0d | got oc %0d last %0b h %0d m %0d e %0d",
                     e.oc, e.last, e.hits, e.misses, e.evicts,
                     out_tuser, out_tlast, out_tdata[31:0], out_tdata[63:32],
                     out_tdata[95:64]);
        end
      end
    end
  end

  // watchdog on cycles with no request moving on either side
  always @(posedge clk) begin : watchdog
    int quiet;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("FAIL set_assoc_lru_cache_sim_unit");
      $finish;
    end
  end

  initial begin
    int               n;
    int               pause_at;
    int               sbe;
    int               nwe;
    int               shift;
    int               r;
    logic [63:0]      set_span;
    logic [63:0]      setv;
    logic [OP_W-1:0]  op;
    logic [ADDR_W-1:0] addr;
    logic [TAG_W-1:0] tag;
    logic [TAG_W-1:0] tag_pool [12];
    logic [CFG_DW-1:0] sb_val;
    logic [CFG_DW-1:0] ways_val;
    logic [CFG_DW-1:0] bb_val;

    // predictor starts from the reset image
    for (int k = 0; k < LINE_SLOTS; k++) begin
      cache_valid[k] = 1'b0;
      cache_tag[k] = '0;
      cache_age[k] = '0;
    end
    hit_cnt = '0;
    miss_cnt = '0;
    evict_cnt = '0;
    cur_set_bits = '0;
    cur_ways = 4'd1;
    cur_block_bits = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].is_cfg) begin
        drain();
        cfg_write(dir_rows[i].sel, dir_rows[i].value[CFG_DW-1:0]);
      end else begin
        send_record(dir_rows[i].sel, dir_rows[i].value);
        if (dir_rows[i].typed) begin
          void'(expected_results.pop_back());
          expected_results.push_back('{dir_rows[i].oc, 1'b1, dir_rows[i].hits,
                                       dir_rows[i].misses, dir_rows[i].evicts});
        end
      end
    end

    // random phases, each under its own setting
    while (records_sent < RECORD_GOAL) begin
      drain();
      case ($urandom_range(0, 4))
        0: sb_val = 0;
        1: sb_val = 6;
        2: sb_val = 7;
        default: sb_val = $urandom_range(1, 5);
      endcase
      case ($urandom_range(0, 5))
        0: ways_val = 0;
        1: ways_val = 1;
        2: ways_val = 8;
        3: ways_val = $urandom_range(9, 15);
        default: ways_val = $urandom_range(2, 7);
      endcase
      case ($urandom_range(0, 5))
        0: bb_val = 58;
        1: bb_val = 63;
        2: bb_val = 0;
        default: bb_val = $urandom_range(1, 12);
      endcase
      cfg_write(REG_SET_BITS, sb_val);
      cfg_write(REG_WAYS, ways_val);
      cfg_write(REG_BLOCK_BITS, bb_val);

      gaps_on = ($urandom_range(0, 2) != 0);
      for (int t = 0; t < 12; t++) tag_pool[t] = {$urandom, $urandom};
      set_span = $urandom_range(0, 1) ? 64'd3 : 64'd63;
      n = $urandom_range(40, 100);
      pause_at = $urandom_range(10, n - 1);

      for (int i = 0; i < n; i++) begin
        // hold off until the block has caught up completely
        if (i == pause_at && (phases == 0 || $urandom_range(0, 2) == 0)) drain();
        r = $urandom_range(0, 19);
        if (r < 7) op = OP_LOAD;
        else if (r < 13) op = OP_STORE;
        else if (r < 19) op = OP_MODIFY;
        else op = OP_NONE;
        if ($urandom_range(0, 6) == 0) begin
          addr = {$urandom, $urandom};
        end else begin
          // tag from a small pool so sets fill, hit and replace
          sbe = sets_log();
          nwe = ways_live();
          shift = int'(cur_block_bits) + sbe;
          tag = tag_pool[$urandom_range(0, nwe + 1)];
          setv = 64'($urandom) & set_span & ((64'd1 << sbe) - 64'd1);
          addr = ((shift >= 64) ? 64'd0 : (tag << shift)) | (setv << cur_block_bits) |
                 ({$urandom, $urandom} & ((64'd1 << cur_block_bits) - 64'd1));
        end
        send_record(op, addr);
      end
      phases++;
    end

    drain();
    errors += expected_results.size();

    $display("covered %0d records over %0d random settings plus directed rows",
             records_sent, phases);
    $display("checked %0d results: %0d hits, %0d fills, %0d evictions",
             results_seen, seen_hits, seen_fills, seen_evicts);
    if (errors == 0) begin
      $display("PASS set_assoc_lru_cache_sim_unit");
    end else begin
      $display("%0d failures", errors);
      $display("FAIL set_assoc_lru_cache_sim_unit");
    end
    $finish;
  end

endmodule
